[src/ovl_pkg.sv]
package ovl_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND       = 3'd0,
        ACT_DROP_LAST    = 3'd1,
        ACT_INSERT       = 3'd2,
        ACT_REMOVE_AT    = 3'd3,
        ACT_REMOVE_VALUE = 3'd4,
        ACT_CONTAINS     = 3'd5,
        ACT_READ         = 3'd6,
        ACT_CLEAR        = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cell_cmd_t;

    // Control part of the probe that walks the chain
    typedef struct packed {
        logic valid;
        logic is_read;
        logic hit;
    } probe_ctl_t;

endpackage

[src/ordered_value_list.sv]
// Ordered value list: up to DEPTH values kept in a chain of cells, plus a count.
// Request channel: in_valid / in_stall with action, index and value; a transaction
// takes place at a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with read_value, found, status and count;
// exactly one result per request, in request order.
// Append, drop last, insert, remove at index, clear and any request that fails its
// index check need no probe: the result is registered at the accepting edge.
// Contains, remove value and a valid read send a probe down the chain, one cell per
// cycle, through the head register and each cell; the result then waits in the
// pending registers until the output register frees. No new request is taken
// while a probe is in flight. Insert and remove shift all later cells by one place.
// The output register holds a result while out_stall is high; a probe request may
// still be accepted then, but a non-probe request waits until the slot frees.
// Reset clears the count, the probe chain and the output valid; stored entries are
// not cleared and stay invisible until written.
module ordered_value_list #(
    parameter int DEPTH      = ovl_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ovl_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ovl_pkg::ACTION_W-1:0]  action,
    input  logic [ovl_pkg::INDEX_W-1:0]   index,
    input  logic [ovl_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ovl_pkg::VALUE_W-1:0]   read_value,
    output logic                          found,
    output logic [ovl_pkg::STATUS_W-1:0]  status,
    output logic [ovl_pkg::COUNT_W-1:0]   count
);

    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ovl_pkg::INDEX_W) ? CNT_W : ovl_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_HOLD = 2'd2
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    logic                          out_valid_reg;
    logic [ovl_pkg::VALUE_W-1:0]   read_value_reg;
    logic                          found_reg;
    ovl_pkg::status_t              status_reg;
    logic [ovl_pkg::COUNT_W-1:0]   count_out_reg;

    logic [ovl_pkg::VALUE_W-1:0]   pend_value_reg;
    logic                          pend_found_reg;
    logic [ovl_pkg::COUNT_W-1:0]   pend_count_reg;
    logic                          remove_reg;

    ovl_pkg::probe_ctl_t           head_ctl_reg;
    logic [POS_W-1:0]              head_pos_reg;
    logic [DATA_WIDTH-1:0]         head_word_reg;

    ovl_pkg::probe_ctl_t           probe_ctl  [DEPTH+1];
    logic [POS_W-1:0]              probe_pos  [DEPTH+1];
    logic [DATA_WIDTH-1:0]         probe_word [DEPTH+1];
    logic [DATA_WIDTH-1:0]         entry_w    [DEPTH];

    ovl_pkg::action_t              act;
    ovl_pkg::status_t              imm_status;
    ovl_pkg::cell_cmd_t            cmd;
    logic [POS_W-1:0]              cmd_pos;
    logic [DATA_WIDTH-1:0]         cmd_word;
    logic [CMP_W-1:0]              idx_ext;
    logic [CMP_W-1:0]              cnt_ext;
    logic [DATA_WIDTH-1:0]         value_dw;
    logic                          out_free;
    logic                          read_ok;
    logic                          is_scan;
    logic                          accept;
    logic                          full;
    logic                          out_load;
    ovl_pkg::probe_ctl_t           tail_ctl;

    assign tail_ctl = probe_ctl[DEPTH];

    always_comb
    begin
        act        = ovl_pkg::action_t'(action);
        idx_ext    = CMP_W'(index);
        cnt_ext    = CMP_W'(count_reg);
        value_dw   = DATA_WIDTH'(value);
        full       = count_reg == CNT_W'(DEPTH);
        out_free   = !out_valid_reg || !out_stall;
        read_ok    = idx_ext < cnt_ext;
        is_scan    = act inside {ovl_pkg::ACT_REMOVE_VALUE, ovl_pkg::ACT_CONTAINS}
                     || (act == ovl_pkg::ACT_READ && read_ok);
        in_stall   = (state_reg != S_IDLE) || (!out_free && !is_scan);
        accept     = in_valid && !in_stall;

        cmd        = ovl_pkg::CMD_NONE;
        cmd_pos    = POS_W'(idx_ext);
        cmd_word   = value_dw;
        count_next = count_reg;
        imm_status = ovl_pkg::STAT_DONE;

        if (accept)
        begin
            case (act)
                ovl_pkg::ACT_APPEND:
                begin
                    if (full)
                        imm_status = ovl_pkg::STAT_FULL;
                    else
                    begin
                        cmd        = ovl_pkg::CMD_WRITE;
                        cmd_pos    = POS_W'(count_reg);
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                end
                ovl_pkg::ACT_DROP_LAST:
                begin
                    if (count_reg == '0)
                        imm_status = ovl_pkg::STAT_BAD;
                    else
                        count_next = CNT_W'(count_reg - 1'b1);
                end
                ovl_pkg::ACT_INSERT:
                begin
                    if (idx_ext > cnt_ext)
                        imm_status = ovl_pkg::STAT_BAD;
                    else if (full)
                        imm_status = ovl_pkg::STAT_FULL;
                    else
                    begin
                        cmd        = ovl_pkg::CMD_INSERT;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                end
                ovl_pkg::ACT_REMOVE_AT:
                begin
                    if (!read_ok)
                        imm_status = ovl_pkg::STAT_BAD;
                    else
                    begin
                        cmd        = ovl_pkg::CMD_REMOVE;
                        count_next = CNT_W'(count_reg - 1'b1);
                    end
                end
                ovl_pkg::ACT_READ:
                begin
                    if (!read_ok)
                        imm_status = ovl_pkg::STAT_BAD;
                end
                ovl_pkg::ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    imm_status = ovl_pkg::STAT_DONE;
                end
            endcase
        end

        // Remove the first match once the probe leaves the chain
        if (state_reg == S_SCAN && tail_ctl.valid && remove_reg && tail_ctl.hit)
        begin
            cmd        = ovl_pkg::CMD_REMOVE;
            cmd_pos    = probe_pos[DEPTH];
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    assign out_load = (accept && !is_scan) || (state_reg == S_HOLD && out_free);

    assign probe_ctl[0]  = head_ctl_reg;
    assign probe_pos[0]  = head_pos_reg;
    assign probe_word[0] = head_word_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cmd_word;
        end
        else
        begin : g_mid_left
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = entry_w[i];
        end
        else
        begin : g_mid_right
            assign right_w = entry_w[i+1];
        end

        ovl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (POS_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .cmd_pos        (cmd_pos),
            .cmd_word       (cmd_word),
            .entry_count    (count_reg),
            .left_entry     (left_w),
            .right_entry    (right_w),
            .probe_in_ctl   (probe_ctl[i]),
            .probe_in_pos   (probe_pos[i]),
            .probe_in_word  (probe_word[i]),
            .probe_out_ctl  (probe_ctl[i+1]),
            .probe_out_pos  (probe_pos[i+1]),
            .probe_out_word (probe_word[i+1]),
            .entry          (entry_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            found_reg      <= 1'b0;
            status_reg     <= ovl_pkg::STAT_DONE;
            count_out_reg  <= '0;
            pend_value_reg <= '0;
            pend_found_reg <= 1'b0;
            pend_count_reg <= '0;
            remove_reg     <= 1'b0;
            head_ctl_reg   <= '0;
            head_pos_reg   <= '0;
            head_word_reg  <= '0;
        end
        else
        begin
            head_ctl_reg.valid <= accept && is_scan;
            count_reg          <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_scan)
                        begin
                            head_ctl_reg.is_read <= act == ovl_pkg::ACT_READ;
                            head_ctl_reg.hit     <= 1'b0;
                            head_pos_reg         <= POS_W'(idx_ext);
                            head_word_reg        <= value_dw;
                            remove_reg           <= act == ovl_pkg::ACT_REMOVE_VALUE;
                            state_reg            <= S_SCAN;
                        end
                        else
                        begin
                            read_value_reg <= '0;
                            found_reg      <= 1'b0;
                            status_reg     <= imm_status;
                            count_out_reg  <= ovl_pkg::COUNT_W'(count_next);
                        end
                    end
                end
                S_SCAN:
                begin
                    if (tail_ctl.valid)
                    begin
                        pend_value_reg <= tail_ctl.is_read
                                          ? ovl_pkg::VALUE_W'(probe_word[DEPTH]) : '0;
                        pend_found_reg <= tail_ctl.hit;
                        pend_count_reg <= ovl_pkg::COUNT_W'(count_next);
                        state_reg      <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    // Hold the result until the output register frees up
                    if (out_free)
                    begin
                        read_value_reg <= pend_value_reg;
                        found_reg      <= pend_found_reg;
                        status_reg     <= ovl_pkg::STAT_DONE;
                        count_out_reg  <= pend_count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign status     = status_reg;
    assign count      = count_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("request taken while a probe is in flight");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail_ctl.valid |-> state_reg == S_SCAN)
        else $error("probe left the chain outside a scan");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_scan |=> state_reg == S_SCAN && head_ctl_reg.valid)
        else $error("scan request did not launch a probe");

    a_read_hits: assert property (@(posedge clk) disable iff (!rst_n)
        tail_ctl.valid && tail_ctl.is_read |-> tail_ctl.hit)
        else $error("read probe missed its slot");
`endif

endmodule

[src/ovl_cell.sv]
module ovl_cell #(
    parameter int DATA_WIDTH = ovl_pkg::DATA_WIDTH_DEFAULT,
    parameter int POS_W      = 6,
    parameter int CNT_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ovl_pkg::cell_cmd_t       cmd,
    input  logic [POS_W-1:0]         cmd_pos,
    input  logic [DATA_WIDTH-1:0]    cmd_word,
    input  logic [CNT_W-1:0]         entry_count,
    input  logic [DATA_WIDTH-1:0]    left_entry,
    input  logic [DATA_WIDTH-1:0]    right_entry,
    input  ovl_pkg::probe_ctl_t      probe_in_ctl,
    input  logic [POS_W-1:0]         probe_in_pos,
    input  logic [DATA_WIDTH-1:0]    probe_in_word,
    output ovl_pkg::probe_ctl_t      probe_out_ctl,
    output logic [POS_W-1:0]         probe_out_pos,
    output logic [DATA_WIDTH-1:0]    probe_out_word,
    output logic [DATA_WIDTH-1:0]    entry
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    ovl_pkg::probe_ctl_t   probe_ctl_reg;
    ovl_pkg::probe_ctl_t   probe_ctl_next;
    logic [POS_W-1:0]      probe_pos_reg;
    logic [POS_W-1:0]      probe_pos_next;
    logic [DATA_WIDTH-1:0] probe_word_reg;
    logic [DATA_WIDTH-1:0] probe_word_next;
    logic                  in_list;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd)
            ovl_pkg::CMD_WRITE:
            begin
                if (cmd_pos == MY_POS)
                    entry_next = cmd_word;
            end
            ovl_pkg::CMD_INSERT:
            begin
                if (MY_POS > cmd_pos)
                    entry_next = left_entry;
                else if (MY_POS == cmd_pos)
                    entry_next = cmd_word;
            end
            ovl_pkg::CMD_REMOVE:
            begin
                if (MY_POS >= cmd_pos)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        in_list         = MY_CNT < entry_count;
        probe_ctl_next  = probe_in_ctl;
        probe_pos_next  = probe_in_pos;
        probe_word_next = probe_in_word;
        if (probe_in_ctl.valid)
        begin
            if (probe_in_ctl.is_read)
            begin
                // Read: pick up the entry as the probe passes the target slot
                if (probe_in_pos == MY_POS)
                begin
                    probe_word_next    = entry_reg;
                    probe_ctl_next.hit = 1'b1;
                end
            end
            else if (!probe_in_ctl.hit && in_list && entry_reg == probe_in_word)
            begin
                // Search: only the first match marks its position
                probe_ctl_next.hit = 1'b1;
                probe_pos_next     = MY_POS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg      <= entry_next;
        probe_pos_reg  <= probe_pos_next;
        probe_word_reg <= probe_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_ctl_reg <= '0;
        else
            probe_ctl_reg <= probe_ctl_next;
    end

    assign entry          = entry_reg;
    assign probe_out_ctl  = probe_ctl_reg;
    assign probe_out_pos  = probe_pos_reg;
    assign probe_out_word = probe_word_reg;

endmodule

[bench/ovl_result_checker.sv]
`timescale 1ns / 1ps

module ovl_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [ovl_pkg::ACTION_W-1:0]  action,
    input  logic [ovl_pkg::INDEX_W-1:0]   index,
    input  logic [ovl_pkg::VALUE_W-1:0]   value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ovl_pkg::VALUE_W-1:0]   read_value,
    input  logic                          found,
    input  logic [ovl_pkg::STATUS_W-1:0]  status,
    input  logic [ovl_pkg::COUNT_W-1:0]   count,
    output int                            fail_count,
    output int                            pending
);

    localparam int LIST_DEPTH = ovl_pkg::DEPTH_DEFAULT;

    typedef struct packed {
        logic [ovl_pkg::VALUE_W-1:0] read_value;
        logic                        found;
        ovl_pkg::status_t            status;
        logic [ovl_pkg::COUNT_W-1:0] count;
    } list_result_t;

    logic [ovl_pkg::VALUE_W-1:0] shadow_list [LIST_DEPTH];
    int                          shadow_len = 0;
    list_result_t                expected_results [$];
    int                          mismatches = 0;

    // Carry out one request on the shadow list and return the result it must produce.
    function automatic list_result_t apply_request(ovl_pkg::action_t act, int idx,
                                                   logic [ovl_pkg::VALUE_W-1:0] v);
        list_result_t r;
        int           pos;
        int           i;
        r.read_value = '0;
        r.found      = 1'b0;
        r.status     = ovl_pkg::STAT_DONE;
        pos          = -1;
        case (act)
            ovl_pkg::ACT_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.status = ovl_pkg::STAT_FULL;
                else
                begin
                    shadow_list[shadow_len] = v;
                    shadow_len++;
                end
            end
            ovl_pkg::ACT_DROP_LAST:
            begin
                if (shadow_len == 0)
                    r.status = ovl_pkg::STAT_BAD;
                else
                    shadow_len--;
            end
            ovl_pkg::ACT_INSERT:
            begin
                // a bad index wins over a full list
                if (idx > shadow_len)
                    r.status = ovl_pkg::STAT_BAD;
                else if (shadow_len >= LIST_DEPTH)
                    r.status = ovl_pkg::STAT_FULL;
                else
                begin
                    for (i = shadow_len; i > idx; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[idx] = v;
                    shadow_len++;
                end
            end
            ovl_pkg::ACT_REMOVE_AT:
            begin
                if (idx >= shadow_len)
                    r.status = ovl_pkg::STAT_BAD;
                else
                    pos = idx;
            end
            ovl_pkg::ACT_REMOVE_VALUE, ovl_pkg::ACT_CONTAINS:
            begin
                for (i = 0; i < shadow_len; i++)
                    if (pos < 0 && shadow_list[i] == v)
                        pos = i;
                r.found = (pos >= 0);
                if (act == ovl_pkg::ACT_CONTAINS)
                    pos = -1;
            end
            ovl_pkg::ACT_READ:
            begin
                if (idx >= shadow_len)
                    r.status = ovl_pkg::STAT_BAD;
                else
                begin
                    r.read_value = shadow_list[idx];
                    r.found      = 1'b1;
                end
            end
            default:
                shadow_len = 0;
        endcase
        // close the gap left by a removed entry
        if (pos >= 0)
        begin
            for (i = pos; i < shadow_len - 1; i++)
                shadow_list[i] = shadow_list[i + 1];
            shadow_len--;
        end
        r.count = shadow_len[ovl_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value, read_value);
                        mismatches++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %b, got %b", want.found, found);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(
                    apply_request(ovl_pkg::action_t'(action), int'(index), value));
        end
        fail_count <= mismatches;
        pending    <= expected_results.size();
    end

endmodule

[bench/ordered_value_list_tb.sv]
`timescale 1ns / 1ps

module ordered_value_list_tb;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * (ovl_pkg::DEPTH_DEFAULT + 3);

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    ovl_pkg::action_t             action;
    logic [ovl_pkg::INDEX_W-1:0]  index;
    logic [ovl_pkg::VALUE_W-1:0]  value;
    logic                         out_valid;
    logic                         out_stall;
    logic [ovl_pkg::VALUE_W-1:0]  read_value;
    logic                         found;
    logic [ovl_pkg::STATUS_W-1:0] status;
    logic [ovl_pkg::COUNT_W-1:0]  count;
    int                           fail_count;
    int                           pending;
    int                           hold_requests = 0;
    int                           hold_served = 0;

    // action mix in percent for fill, drain and mixed phases
    int mix_weight [3][8] = '{'{40, 4, 25, 4, 4, 10, 12, 1},
                              '{8, 20, 6, 22, 16, 12, 14, 2},
                              '{18, 10, 16, 12, 12, 14, 16, 2}};

    ordered_value_list DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .found      (found),
        .status     (status),
        .count      (count)
    );

    ovl_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .found      (found),
        .status     (status),
        .count      (count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Present one request, hold it until taken, then, if gaps are enabled, idle for a random gap.
    task automatic offer(ovl_pkg::action_t act, logic [ovl_pkg::INDEX_W-1:0] idx,
                         logic [ovl_pkg::VALUE_W-1:0] v, bit with_gaps);
        int roll;
        int gap;
        in_valid <= 1'b1;
        action   <= act;
        index    <= idx;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        roll = $urandom_range(0, 99);
        gap  = 0;
        if (with_gaps)
        begin
            if (roll >= 98)
                gap = $urandom_range(20, 40);
            else if (roll >= 90)
                gap = $urandom_range(4, 10);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : result_sink
        int free_run;
        int stall_run;
        int roll;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_served != hold_requests)
            begin
                // hold off long enough for the block to back up into its input
                hold_served = hold_served + 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
            begin
                free_run = $urandom_range(1, 6);
                roll     = $urandom_range(0, 99);
                if (roll < 70)
                    stall_run = $urandom_range(1, 2);
                else if (roll < 95)
                    stall_run = $urandom_range(3, 8);
                else
                    stall_run = $urandom_range(15, 40);
                out_stall <= 1'b0;
                repeat (free_run) @(posedge clk);
                out_stall <= 1'b1;
                repeat (stall_run) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int                          sent;
        int                          phase_len;
        int                          phase_kind;
        int                          roll;
        int                          acc;
        int                          k;
        int                          j;
        bit                          with_gaps;
        ovl_pkg::action_t            act;
        logic [ovl_pkg::INDEX_W-1:0] idx;
        logic [ovl_pkg::VALUE_W-1:0] v;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ovl_pkg::ACT_APPEND;
        index    <= '0;
        value    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        offer(ovl_pkg::ACT_READ, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_DROP_LAST, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_REMOVE_AT, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_CONTAINS, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_REMOVE_VALUE, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_INSERT, 7'd1, 32'h1, 1'b1);
        // insert at the count appends
        offer(ovl_pkg::ACT_INSERT, 7'd0, 32'hFFFF_FFFF, 1'b1);
        offer(ovl_pkg::ACT_APPEND, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_INSERT, 7'd2, 32'h8000_0000, 1'b1);
        offer(ovl_pkg::ACT_INSERT, 7'd1, 32'h1234_5678, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd1, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd2, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd3, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd4, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd127, 32'hFFFF_FFFF, 1'b1);
        offer(ovl_pkg::ACT_CONTAINS, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_CONTAINS, 7'd0, 32'h7FFF_FFFF, 1'b1);
        offer(ovl_pkg::ACT_REMOVE_VALUE, 7'd0, 32'h1234_5678, 1'b1);
        offer(ovl_pkg::ACT_REMOVE_AT, 7'd127, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_REMOVE_AT, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_DROP_LAST, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_CLEAR, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_READ, 7'd0, 32'h0, 1'b1);
        offer(ovl_pkg::ACT_APPEND, 7'd127, 32'h5A5A_5A5A, 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len  = $urandom_range(60, 160);
            phase_kind = $urandom_range(0, 2);
            with_gaps  = ($urandom_range(0, 3) != 0);
            if (hold_requests < 2 && sent >= hold_requests * (RANDOM_ITEMS / 2))
            begin
                // keep offering back to back while the receiver holds off
                hold_requests = hold_requests + 1;
                phase_kind    = 0;
                with_gaps     = 1'b0;
            end
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                acc  = 0;
                act  = ovl_pkg::ACT_CLEAR;
                for (j = 0; j < 8; j++)
                begin
                    if (roll >= acc && roll < acc + mix_weight[phase_kind][j])
                        act = ovl_pkg::action_t'(j);
                    acc += mix_weight[phase_kind][j];
                end
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    idx = ovl_pkg::INDEX_W'($urandom_range(0, 64));
                else if (roll < 85)
                    idx = ovl_pkg::INDEX_W'($urandom_range(0, 8));
                else
                    idx = ovl_pkg::INDEX_W'($urandom_range(0, 127));
                // small values repeat often so lookups hit
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    v = $urandom_range(0, 15);
                else if (roll < 60)
                    v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                else
                    v = $urandom;
                offer(act, idx, v, with_gaps);
                sent++;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ordered_value_list] OK");
        else
            $display("[ordered_value_list] ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[ordered_value_list] ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/ovl_pkg.sv
src/ovl_cell.sv
src/ordered_value_list.sv
bench/ovl_result_checker.sv
bench/ordered_value_list_tb.sv
